// ===== src/mbrp_pkg.sv =====
// Shared types, constants and the CRC-16 byte step for the reply frame parser.
// No dependencies.
`default_nettype none

package mbrp_pkg;

  localparam int unsigned MAX_FRAME_DEF     = 255;
  localparam int unsigned CAPTURE_DEPTH_DEF = 32;
  // Highest frame offset read for a result is 28.
  localparam int unsigned READ_SPAN         = 29;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [7:0] BATT_HEAD   = 8'hDD;
  localparam logic [7:0] BATT_TERM   = 8'h77;
  localparam logic [7:0] FC_READ     = 8'h03;
  localparam logic [7:0] FC_WR_COILS = 8'h0F;
  localparam logic [7:0] FC_WR_REGS  = 8'h10;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] CFG_EXPECTED = 2'd0;
  localparam logic [1:0] CFG_GAS      = 2'd1;
  localparam logic [1:0] CFG_THERMAL  = 2'd2;

  typedef enum logic [1:0] {
    KIND_GAS,
    KIND_THERMAL,
    KIND_BATTERY,
    KIND_OTHER
  } frame_kind_t;

  // Work the back end does for one byte.
  typedef enum logic [1:0] {
    OP_START,     // first byte: clear crc/sum/tail, then take
    OP_TAKE,      // take byte (capture, tail, delayed crc)
    OP_TAKE_SUM,  // take byte and add it to the battery sum
    OP_FINISH     // take last byte and report the frame
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic       battery;
    logic [7:0] pos;
    logic [7:0] data;
  } cmd_t;

  // CRC-16/Modbus, one byte, reflected.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mbrp_front.sv =====
// Front end: accepts received bytes, tracks frame phase and length, and
// queues one command per byte the frame keeps, and for a count or length byte that drops it. Uses mbrp_pkg.
`default_nettype none

module mbrp_front #(
  parameter int unsigned MAX_FRAME = 255
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic [7:0]    expected_address,
  input  wire logic          q_space,
  output logic               q_push,
  output mbrp_pkg::cmd_t     q_cmd
);
  import mbrp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_FUNC,
    PH_COUNT,
    PH_BLEN,
    PH_MBODY,
    PH_BBODY
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [8:0]  rem_dec;
  logic [8:0]  byte_ext;
  logic        mb_len_ok;
  logic        bt_len_bad;
  logic        accept;

  assign accept     = in_valid && q_space;
  assign byte_ext   = {1'b0, in_byte};
  assign rem_dec    = rem_r - 9'd1;
  assign mb_len_ok  = (byte_ext + 9'd5) <= 9'(MAX_FRAME);
  assign bt_len_bad = (byte_ext + 9'd7) > 9'(MAX_FRAME);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    head_nxt    = head_r;
    func_nxt    = func_r;
    q_push      = 1'b0;
    q_cmd       = '{op: OP_TAKE, battery: 1'b0, pos: pos_r, data: in_byte};
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_byte == expected_address) begin
            q_push    = 1'b1;
            q_cmd.op  = OP_START;
            q_cmd.pos = 8'd0;
            head_nxt  = in_byte;
            pos_nxt   = 8'd1;
            phase_nxt = PH_FUNC;
          end
        end
        PH_FUNC: begin
          if (in_byte == FC_READ || in_byte == FC_WR_COILS || in_byte == FC_WR_REGS) begin
            q_push    = 1'b1;
            func_nxt  = in_byte;
            pos_nxt   = pos_r + 8'd1;
            phase_nxt = PH_COUNT;
          end else begin
            phase_nxt = PH_HUNT;
            pos_nxt   = 8'd0;
            rem_nxt   = 9'd0;
          end
        end
        PH_COUNT: begin
          // byte is captured even when the frame is dropped here
          q_push  = 1'b1;
          pos_nxt = pos_r + 8'd1;
          if (head_r == BATT_HEAD && in_byte == 8'd0) begin
            q_cmd.op  = OP_TAKE_SUM;
            phase_nxt = PH_BLEN;
          end else if (func_r == FC_READ && mb_len_ok) begin
            rem_nxt   = byte_ext + 9'd2;
            phase_nxt = PH_MBODY;
          end else begin
            phase_nxt = PH_HUNT;
            pos_nxt   = 8'd0;
            rem_nxt   = 9'd0;
          end
        end
        PH_BLEN: begin
          q_push   = 1'b1;
          q_cmd.op = OP_TAKE_SUM;
          if (bt_len_bad) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = 8'd0;
            rem_nxt   = 9'd0;
          end else begin
            rem_nxt   = byte_ext + 9'd3;
            pos_nxt   = pos_r + 8'd1;
            phase_nxt = PH_BBODY;
          end
        end
        PH_MBODY, PH_BBODY: begin
          if (rem_r == 9'd0) begin
            phase_nxt = PH_HUNT;
            pos_nxt   = 8'd0;
          end else begin
            q_push  = 1'b1;
            rem_nxt = rem_dec;
            pos_nxt = pos_r + 8'd1;
            if (rem_dec == 9'd0) begin
              q_cmd.op      = OP_FINISH;
              q_cmd.battery = (phase_r == PH_BBODY);
              phase_nxt     = PH_HUNT;
              pos_nxt       = 8'd0;
            end else if (phase_r == PH_BBODY && rem_r > 9'd3) begin
              // data bytes only; checksum and terminator stay out of the sum
              q_cmd.op = OP_TAKE_SUM;
            end
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          pos_nxt   = 8'd0;
          rem_nxt   = 9'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= 8'd0;
      rem_r   <= 9'd0;
      head_r  <= 8'd0;
      func_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      head_r  <= head_nxt;
      func_r  <= func_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/mbrp_queue.sv =====
// Short command queue between front and back ends of the parser.
// Uses mbrp_pkg (cmd_t, QUEUE_DEPTH).
`default_nettype none

module mbrp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mbrp_pkg::cmd_t  push_cmd,
  output logic                 space,
  input  wire logic            pop,
  output logic                 head_valid,
  output mbrp_pkg::cmd_t       head_cmd
);
  import mbrp_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign space      = cnt_r != CW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/mbrp_back.sv =====
// Back end: capture store, running CRC-16 and battery sum, and the result
// register that reports each finished frame. Uses mbrp_pkg.
`default_nettype none

module mbrp_back #(
  parameter int unsigned CAPTURE_DEPTH = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  input  wire mbrp_pkg::cmd_t  cmd,
  output logic                 cmd_pop,
  input  wire logic [7:0]      gas_address,
  input  wire logic [7:0]      thermal_address,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_checksum_ok,
  output logic [1:0]           out_frame_kind,
  output logic [15:0]          out_word_a,
  output logic [15:0]          out_word_b,
  output logic [15:0]          out_word_c,
  output logic [15:0]          out_word_d,
  output logic [7:0]           out_frame_length
);
  import mbrp_pkg::*;

  // Only offsets that a result reads need storage.
  localparam int unsigned CAP_KEEP =
    (CAPTURE_DEPTH < READ_SPAN) ? CAPTURE_DEPTH : READ_SPAN;

  logic [7:0]  cap_r [CAP_KEEP];
  logic [7:0]  cap_view [READ_SPAN];
  logic [15:0] crc_r, sum_r, tail_r;
  logic [15:0] base_crc, base_sum, base_tail;
  logic [15:0] crc_new, sum_new, tail_new;
  logic        ok_batt, ok_crc, ok;
  logic        out_free;
  logic        is_finish;
  frame_kind_t kind;
  logic [15:0] wa, wb, wc, wd;

  logic        out_valid_r;
  logic        ok_r;
  frame_kind_t kind_r;
  logic [15:0] wa_r, wb_r, wc_r, wd_r;
  logic [7:0]  len_r;

  assign out_free  = !out_valid_r || out_ready;
  assign is_finish = cmd.op == OP_FINISH;
  assign cmd_pop   = cmd_valid && (!is_finish || out_free);

  // Capture view with the byte being taken bypassed in.
  for (genvar i = 0; i < READ_SPAN; i++) begin : g_view
    if (i < CAP_KEEP) begin : g_kept
      assign cap_view[i] = (cmd.pos == 8'(i)) ? cmd.data : cap_r[i];
    end else begin : g_none
      assign cap_view[i] = 8'h00;
    end
  end

  always_comb begin
    base_crc  = (cmd.op == OP_START) ? CRC_INIT : crc_r;
    base_sum  = (cmd.op == OP_START) ? 16'h0000 : sum_r;
    base_tail = (cmd.op == OP_START) ? 16'h0000 : tail_r;
    // crc runs two bytes behind so the trailing CRC itself is left out
    crc_new   = (cmd.pos >= 8'd2) ? crc16_byte(base_crc, base_tail[15:8]) : base_crc;
    tail_new  = {base_tail[7:0], cmd.data};
    sum_new   = (cmd.op == OP_TAKE_SUM) ? base_sum + {8'h00, cmd.data} : base_sum;
    ok_batt   = (16'h0000 - sum_r) == tail_r;
    ok_crc    = crc_new == {tail_new[7:0], tail_new[15:8]};
    ok        = (cmd.battery && cmd.data == BATT_TERM) ? ok_batt : ok_crc;

    wa = 16'h0000;
    wb = 16'h0000;
    wc = 16'h0000;
    wd = 16'h0000;
    if (cap_view[0] == gas_address) begin
      kind = KIND_GAS;
      wa   = {cap_view[3], cap_view[4]};
      wb   = {cap_view[5], cap_view[6]};
      wc   = {cap_view[13], cap_view[14]};
      wd   = {cap_view[15], cap_view[16]};
    end else if (cap_view[0] == thermal_address) begin
      kind = KIND_THERMAL;
      wa   = {cap_view[3], cap_view[4]};
      wb   = {cap_view[5], cap_view[6]};
      wc   = {cap_view[9], cap_view[10]};
    end else if (cap_view[0] == BATT_HEAD) begin
      kind = KIND_BATTERY;
      wa   = {cap_view[4], cap_view[5]};
      wb   = {cap_view[6], cap_view[7]};
      wc   = {8'h00, cap_view[23]};
      wd   = {cap_view[27], cap_view[28]};
    end else begin
      kind = KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      sum_r       <= 16'h0000;
      tail_r      <= 16'h0000;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CAP_KEEP; i++) begin
        cap_r[i] <= 8'h00;
      end
    end else begin
      if (cmd_pop) begin
        crc_r  <= crc_new;
        sum_r  <= sum_new;
        tail_r <= tail_new;
        for (int i = 0; i < CAP_KEEP; i++) begin
          if (cmd.pos == 8'(i)) begin
            cap_r[i] <= cmd.data;
          end
        end
      end
      if (cmd_pop && is_finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd_pop && is_finish) begin
      ok_r   <= ok;
      kind_r <= kind;
      wa_r   <= wa;
      wb_r   <= wb;
      wc_r   <= wc;
      wd_r   <= wd;
      len_r  <= cmd.pos + 8'd1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_checksum_ok  = ok_r;
  assign out_frame_kind   = 2'(kind_r);
  assign out_word_a       = wa_r;
  assign out_word_b       = wb_r;
  assign out_word_c       = wc_r;
  assign out_word_d       = wd_r;
  assign out_frame_length = len_r;

endmodule

`default_nettype wire

// ===== src/modbus_bms_reply_frame_parser_top.sv =====
// Top level of the Modbus RTU / battery reply frame parser: config registers,
// front end, command queue and back end. Uses mbrp_pkg and the mbrp_* modules.
`default_nettype none

// Takes one received byte per clock with no gaps, indefinitely. The front end
// decides per byte what the frame does with it; the back end applies one
// byte per cycle, the bound being its single-byte CRC-16 step. A frame's
// result is registered once the back end takes its last byte from the queue and
// waits in the output register while further bytes keep flowing; only a
// stalled result with a second frame finishing behind it holds off input,
// once the two-entry command queue is full. No clearing pass after reset.
module modbus_bms_reply_frame_parser_top #(
  parameter int unsigned MAX_FRAME     = mbrp_pkg::MAX_FRAME_DEF,
  parameter int unsigned CAPTURE_DEPTH = mbrp_pkg::CAPTURE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_checksum_ok,
  output logic [1:0]       out_frame_kind,
  output logic [15:0]      out_word_a,
  output logic [15:0]      out_word_b,
  output logic [15:0]      out_word_c,
  output logic [15:0]      out_word_d,
  output logic [7:0]       out_frame_length,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import mbrp_pkg::*;

  logic [7:0] expected_address_r;
  logic [7:0] gas_address_r;
  logic [7:0] thermal_address_r;

  logic       q_push;
  cmd_t       q_cmd;
  logic       q_space;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_address_r <= 8'd1;
      gas_address_r      <= 8'd1;
      thermal_address_r  <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED: expected_address_r <= cfg_data;
        CFG_GAS:      gas_address_r      <= cfg_data;
        CFG_THERMAL:  thermal_address_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = q_space;

  mbrp_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_byte          (in_rx_byte),
    .expected_address (expected_address_r),
    .q_space          (q_space),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  mbrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .space      (q_space),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  mbrp_back #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (q_valid),
    .cmd              (q_head),
    .cmd_pop          (q_pop),
    .gas_address      (gas_address_r),
    .thermal_address  (thermal_address_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_checksum_ok  (out_checksum_ok),
    .out_frame_kind   (out_frame_kind),
    .out_word_a       (out_word_a),
    .out_word_b       (out_word_b),
    .out_word_c       (out_word_c),
    .out_word_d       (out_word_d),
    .out_frame_length (out_frame_length)
  );

endmodule

`default_nettype wire

// ===== tb/modbus_bms_reply_frame_parser_top_tb.sv =====
// Testbench for the Modbus RTU / battery reply frame parser: byte stimulus,
// a predictor of each frame report and a scoreboard that checks them in order.
// Depends on mbrp_pkg and modbus_bms_reply_frame_parser_top.

module modbus_bms_reply_frame_parser_top_tb;
  import mbrp_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 300;

  // No register sits at this index; writes to it must be ignored.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    SEEK_ADDR,
    SEEK_FUNC,
    SEEK_COUNT,
    SEEK_BLEN,
    MODBUS_BODY,
    BATT_BODY
  } parse_phase_t;

  typedef struct packed {
    logic        ok;
    frame_kind_t kind;
    logic [15:0] wa;
    logic [15:0] wb;
    logic [15:0] wc;
    logic [15:0] wd;
    logic [7:0]  len;
  } frame_report_t;

  class frame_reply_checker;
    logic [7:0]    exp_addr;
    logic [7:0]    gas_addr;
    logic [7:0]    thermal_addr;
    parse_phase_t  phase;
    logic [7:0]    pos;
    logic [8:0]    to_go;
    logic [15:0]   crc;
    logic [15:0]   sum;
    logic [15:0]   tail;
    logic [7:0]    cap [CAPTURE_DEPTH_DEF];
    frame_report_t pending [$];
    int            errors;

    function new();
      exp_addr     = 8'd1;
      gas_addr     = 8'd1;
      thermal_addr = 8'd2;
      phase        = SEEK_ADDR;
      pos          = '0;
      to_go        = '0;
      crc          = CRC_INIT;
      sum          = '0;
      tail         = '0;
      foreach (cap[i]) cap[i] = '0;
      errors       = 0;
    endfunction

    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        fb = r[0];
        r  = {1'b0, r[15:1]};
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
      case (idx)
        CFG_EXPECTED: exp_addr = v;
        CFG_GAS:      gas_addr = v;
        CFG_THERMAL:  thermal_addr = v;
        default: ;
      endcase
    endfunction

    function logic [7:0] cap_at(int unsigned i);
      return (i < CAPTURE_DEPTH_DEF) ? cap[i] : 8'h00;
    endfunction

    function logic [15:0] cap_word(int unsigned hi);
      return {cap_at(hi), cap_at(hi + 1)};
    endfunction

    // CRC runs two bytes behind, so the trailer never enters it.
    function void take(logic [7:0] b);
      if (pos >= 8'd2) crc = crc_byte(crc, tail[15:8]);
      tail = {tail[7:0], b};
      if (pos < CAPTURE_DEPTH_DEF) cap[pos] = b;
      pos = pos + 8'd1;
    endfunction

    function void rehunt();
      phase = SEEK_ADDR;
      pos   = '0;
      to_go = '0;
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [15:0]   prev_tail;
      logic          batt;
      frame_report_t r;
      case (phase)
        SEEK_ADDR: begin
          if (b == exp_addr) begin
            crc  = CRC_INIT;
            sum  = '0;
            tail = '0;
            pos  = '0;
            take(b);
            phase = SEEK_FUNC;
          end
        end
        SEEK_FUNC: begin
          if (b == FC_READ || b == FC_WR_COILS || b == FC_WR_REGS) begin
            take(b);
            phase = SEEK_COUNT;
          end else begin
            rehunt();
          end
        end
        SEEK_COUNT: begin
          take(b);
          if (cap_at(0) == BATT_HEAD && b == 8'h00) begin
            phase = SEEK_BLEN;
          end else if (cap_at(1) == FC_READ && int'(b) + 5 <= int'(MAX_FRAME_DEF)) begin
            to_go = {1'b0, b} + 9'd2;
            phase = MODBUS_BODY;
          end else begin
            rehunt();
          end
        end
        SEEK_BLEN: begin
          take(b);
          sum = sum + {8'h00, b};
          if (int'(b) + 7 > int'(MAX_FRAME_DEF)) begin
            rehunt();
          end else begin
            to_go = {1'b0, b} + 9'd3;
            phase = BATT_BODY;
          end
        end
        default: begin
          if (to_go == '0) begin
            rehunt();
          end else begin
            batt      = (phase == BATT_BODY);
            prev_tail = tail;
            take(b);
            // checksum and terminator stay out of the battery sum
            if (batt && to_go > 9'd3) sum = sum + {8'h00, b};
            to_go = to_go - 9'd1;
            if (to_go == '0) begin
              r = '0;
              if (batt && b == BATT_TERM) r.ok = ((16'h0000 - sum) == prev_tail);
              else r.ok = (crc == {tail[7:0], tail[15:8]});
              if (cap_at(0) == gas_addr) begin
                r.kind = KIND_GAS;
                r.wa   = cap_word(3);
                r.wb   = cap_word(5);
                r.wc   = cap_word(13);
                r.wd   = cap_word(15);
              end else if (cap_at(0) == thermal_addr) begin
                r.kind = KIND_THERMAL;
                r.wa   = cap_word(3);
                r.wb   = cap_word(5);
                r.wc   = cap_word(9);
              end else if (cap_at(0) == BATT_HEAD) begin
                r.kind = KIND_BATTERY;
                r.wa   = cap_word(4);
                r.wb   = cap_word(6);
                r.wc   = {8'h00, cap_at(23)};
                r.wd   = cap_word(27);
              end else begin
                r.kind = KIND_OTHER;
              end
              r.len = pos;
              pending.push_back(r);
              rehunt();
            end
          end
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_report(frame_report_t got);
      frame_report_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: frame report with none pending, expected nothing, got %0h",
                 $time, got);
      end else begin
        want = pending.pop_front();
        compare_field("checksum_ok", want.ok, got.ok);
        compare_field("frame_kind", want.kind, got.kind);
        compare_field("word_a", want.wa, got.wa);
        compare_field("word_b", want.wb, got.wb);
        compare_field("word_c", want.wc, got.wc);
        compare_field("word_d", want.wd, got.wd);
        compare_field("frame_length", want.len, got.len);
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_ready  = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_checksum_ok;
  logic [1:0]  out_frame_kind;
  logic [15:0] out_word_a;
  logic [15:0] out_word_b;
  logic [15:0] out_word_c;
  logic [15:0] out_word_d;
  logic [7:0]  out_frame_length;

  frame_report_t      seen_report;
  frame_reply_checker chk;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_req      = 0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;
  int          bytes_sent    = 0;
  logic [7:0]  cur_exp       = 8'd1;
  logic [15:0] run_crc       = CRC_INIT;
  logic [15:0] run_sum       = '0;
  logic [7:0]  tx_q [$];

  assign seen_report = {out_checksum_ok, out_frame_kind, out_word_a, out_word_b,
                        out_word_c, out_word_d, out_frame_length};

  modbus_bms_reply_frame_parser_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_checksum_ok  (out_checksum_ok),
    .out_frame_kind   (out_frame_kind),
    .out_word_a       (out_word_a),
    .out_word_b       (out_word_b),
    .out_word_c       (out_word_c),
    .out_word_d       (out_word_d),
    .out_frame_length (out_frame_length),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stalls, or a long hold when one is requested.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) chk.set_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) chk.note_rx_byte(in_rx_byte);
      if (out_valid && out_ready) chk.check_report(seen_report);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return BATT_HEAD;
      default: return rand_byte();
    endcase
  endfunction

  function automatic logic [7:0] pick_func();
    case ($urandom_range(0, 2))
      0: return FC_READ;
      1: return FC_WR_COILS;
      default: return FC_WR_REGS;
    endcase
  endfunction

  task automatic put(input logic [7:0] b);
    tx_q.push_back(b);
    run_crc = frame_reply_checker::crc_byte(run_crc, b);
    run_sum = run_sum + {8'h00, b};
  endtask

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic flush_tx();
    while (tx_q.size() != 0) send_byte(tx_q.pop_front());
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (chk.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] e, input logic [7:0] g, input logic [7:0] t);
    drain();
    write_reg(CFG_EXPECTED, e);
    write_reg(CFG_GAS, g);
    write_reg(CFG_THERMAL, t);
    cur_exp = e;
  endtask

  task automatic push_modbus(input logic [7:0] addr, input int n, input bit good);
    logic [15:0] c;
    run_crc = CRC_INIT;
    put(addr);
    put(FC_READ);
    put(n[7:0]);
    repeat (n) put(rand_byte());
    c = run_crc;
    if (!good) c = c ^ (16'h0001 << $urandom_range(0, 15));
    put(c[7:0]);
    put(c[15:8]);
  endtask

  task automatic push_battery(input int l, input bit good, input bit term);
    logic [15:0] cs;
    logic [15:0] c;
    logic [7:0]  last;
    run_crc = CRC_INIT;
    put(BATT_HEAD);
    put(pick_func());
    run_sum = '0;
    put(8'h00);
    put(l[7:0]);
    repeat (l) put(rand_byte());
    cs = 16'h0000 - run_sum;
    if (!good) cs = cs ^ (16'h0001 << $urandom_range(0, 15));
    put(cs[15:8]);
    if (term) begin
      put(cs[7:0]);
      put(BATT_TERM);
    end else if ($urandom_range(0, 1) == 0) begin
      // no terminator: a trailing CRC over the rest can still pass
      c = run_crc;
      put(c[7:0]);
      put(c[15:8]);
    end else begin
      put(cs[7:0]);
      last = rand_byte();
      if (last == BATT_TERM) last = last + 8'd1;
      put(last);
    end
  endtask

  task automatic push_random_frame();
    int         sel;
    int         n;
    logic [7:0] f;
    sel = $urandom_range(0, 99);
    if (cur_exp == BATT_HEAD && $urandom_range(0, 1) == 1) begin
      if (sel < 6) begin
        put(BATT_HEAD);
        put(pick_func());
        put(8'h00);
        put(8'($urandom_range(249, 255)));
      end else if (sel < 9) begin
        n = ($urandom_range(0, 2) == 0) ? 248 : $urandom_range(40, 247);
        push_battery(n, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 85);
      end else begin
        push_battery($urandom_range(0, 30), $urandom_range(0, 99) < 85,
                     $urandom_range(0, 99) < 85);
      end
    end else if (sel < 10) begin
      repeat ($urandom_range(1, 6)) put(rand_byte());
    end else if (sel < 15) begin
      put(cur_exp);
      do f = rand_byte();
      while (f == FC_READ || f == FC_WR_COILS || f == FC_WR_REGS);
      put(f);
    end else if (sel < 19) begin
      put(cur_exp);
      put(($urandom_range(0, 1) == 0) ? FC_WR_COILS : FC_WR_REGS);
      put(rand_byte());
      put(rand_byte());
    end else if (sel < 23) begin
      put(cur_exp);
      put(FC_READ);
      put(8'($urandom_range(251, 255)));
    end else if (sel < 27) begin
      // cut short: the following bytes complete it
      n = $urandom_range(4, 20);
      put(cur_exp);
      put(FC_READ);
      put(n[7:0]);
      repeat ($urandom_range(0, n - 1)) put(rand_byte());
    end else if (sel < 29) begin
      n = ($urandom_range(0, 2) == 0) ? 250 : $urandom_range(40, 249);
      push_modbus(cur_exp, n, $urandom_range(0, 99) < 85);
    end else begin
      n = $urandom_range((cur_exp == BATT_HEAD) ? 1 : 0, 30);
      push_modbus(cur_exp, n, $urandom_range(0, 99) < 85);
    end
  endtask

  task automatic random_phase(input int n_bytes);
    int         stop_at;
    logic [7:0] e;
    logic [7:0] g;
    logic [7:0] t;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      e = pick_addr();
      g = ($urandom_range(0, 1) == 0) ? e : pick_addr();
      t = ($urandom_range(0, 1) == 0) ? e : pick_addr();
      apply_config(e, g, t);
      repeat ($urandom_range(3, 8)) push_random_frame();
      flush_tx();
    end
  endtask

  initial begin
    chk = new();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    write_reg(CFG_UNUSED, rand_byte());
    // reset settings: short gas frame reads zeros past its end
    push_modbus(8'd1, 0, 1'b1);
    // unknown function; the dropped byte is not a new address
    put(8'd1);
    put(8'd1);
    put(8'd1);
    put(FC_WR_COILS);
    put(8'd2);
    put(8'd1);
    put(FC_READ);
    put(8'hFB);
    push_modbus(8'd1, 2, 1'b0);
    flush_tx();
    apply_config(BATT_HEAD, 8'd1, 8'd2);
    push_battery(0, 1'b1, 1'b1);
    flush_tx();

    send_idle_pct = 8;
    recv_idle_pct = 55;
    random_phase(320);
    send_idle_pct = 55;
    recv_idle_pct = 8;
    random_phase(320);
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // long result stall while items keep coming, then a full pause
    apply_config(8'hFF, 8'h00, 8'hFF);
    hold_req = HOLD_CYCLES;
    repeat (8) push_modbus(8'hFF, $urandom_range(0, 4), 1'b1);
    flush_tx();
    drain();
    random_phase(320);

    drain();
    if (chk.errors == 0 && chk.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mbrp_pkg.sv
src/mbrp_front.sv
src/mbrp_queue.sv
src/mbrp_back.sv
src/modbus_bms_reply_frame_parser_top.sv
tb/modbus_bms_reply_frame_parser_top_tb.sv
